@@ hdl/ccd_pkg.sv @@
// package for the ccd joint step block: field types, angle constants, cordic table
// no dependencies
package ccd_pkg;

	typedef logic signed [23:0] coord_t;
	typedef logic signed [15:0] angle_t;

	localparam int ANG_HALF    = 23040;
	localparam int ANG_FULL    = 46080;
	localparam int ANG_QUARTER = 11520;
	localparam int KINV_Q30    = 652032874;
	localparam int TABLE_LEN   = 24;

	localparam logic [1:0] OP_PLACE  = 2'd0;
	localparam logic [1:0] OP_ROTATE = 2'd1;
	localparam logic [1:0] OP_SET    = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;

	localparam logic [1:0] REG_LENGTH  = 2'd0;
	localparam logic [1:0] REG_MAX     = 2'd1;
	localparam logic [1:0] REG_INITIAL = 2'd2;

	// arctangent of 2^-i in 2^-15 degree
	function automatic logic [20:0] atan_lut(input logic [4:0] i);
		logic [20:0] r;
		begin
			case (i)
				5'd0: r = 21'd1474560;
				5'd1: r = 21'd870484;
				5'd2: r = 21'd459940;
				5'd3: r = 21'd233473;
				5'd4: r = 21'd117189;
				5'd5: r = 21'd58652;
				5'd6: r = 21'd29333;
				5'd7: r = 21'd14667;
				5'd8: r = 21'd7334;
				5'd9: r = 21'd3667;
				5'd10: r = 21'd1833;
				5'd11: r = 21'd917;
				5'd12: r = 21'd458;
				5'd13: r = 21'd229;
				5'd14: r = 21'd115;
				5'd15: r = 21'd57;
				5'd16: r = 21'd29;
				5'd17: r = 21'd14;
				5'd18: r = 21'd7;
				5'd19: r = 21'd4;
				5'd20: r = 21'd2;
				5'd21: r = 21'd1;
				default: r = 21'd0;
			endcase
			return r;
		end
	endfunction

endpackage

@@ hdl/ccd_in_if.sv @@
// input channel of the ccd joint step block
// depends on ccd_pkg
interface ccd_in_if;
	logic                valid;
	logic                ready;
	logic [1:0]          op;
	ccd_pkg::coord_t     parent_end_x;
	ccd_pkg::coord_t     parent_end_y;
	ccd_pkg::angle_t     parent_angle;
	ccd_pkg::coord_t     target_x;
	ccd_pkg::coord_t     target_y;
	ccd_pkg::coord_t     tip_x;
	ccd_pkg::coord_t     tip_y;
	ccd_pkg::angle_t     new_angle;

	modport source (output valid, op, parent_end_x, parent_end_y, parent_angle,
		target_x, target_y, tip_x, tip_y, new_angle, input ready);
	modport sink (input valid, op, parent_end_x, parent_end_y, parent_angle,
		target_x, target_y, tip_x, tip_y, new_angle, output ready);
endinterface

@@ hdl/ccd_out_if.sv @@
// output channel of the ccd joint step block
// depends on ccd_pkg
interface ccd_out_if;
	logic            valid;
	logic            ready;
	ccd_pkg::coord_t end_x;
	ccd_pkg::coord_t end_y;
	ccd_pkg::angle_t abs_angle;
	ccd_pkg::angle_t joint_angle;

	modport source (output valid, end_x, end_y, abs_angle, joint_angle, input ready);
	modport sink (input valid, end_x, end_y, abs_angle, joint_angle, output ready);
endinterface

@@ hdl/ccd_joint_step_top.sv @@
// top level of the ccd joint step block: sequencer, state registers, config port
// depends on ccd_pkg, ccd_in_if, ccd_out_if, ccd_cordic
//
// one planar arm joint for cyclic coordinate descent. each input transaction
// gives exactly one output transaction with the stored endpoint, absolute angle
// and joint angle. op 0 places the endpoint from the parent through a rotating
// cordic, op 1 turns the joint toward a target through a vectoring cordic, op 2
// loads the joint angle, op 3 only reports. a shared cordic does one micro
// rotation per cycle. for op 1 the cordic is skipped when a vector is zero; the
// cross and dot products go through a single shared multiplier in sequence,
// while scaling and banding use their own multipliers.
// the block takes no new transaction until the result is taken.
// initial_angle is stored but never read; reset sets the joint angle to zero.
module ccd_joint_step_top #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [21:0] cfg_data,
	ccd_in_if.sink      in_ch,
	ccd_out_if.source   out_ch
);
	import ccd_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_PREP  = 4'd1;
	localparam logic [3:0] ST_WAIT  = 4'd2;
	localparam logic [3:0] ST_PFIN  = 4'd3;
	localparam logic [3:0] ST_MUL0  = 4'd4;
	localparam logic [3:0] ST_MUL1  = 4'd5;
	localparam logic [3:0] ST_MUL2  = 4'd6;
	localparam logic [3:0] ST_MUL3  = 4'd7;
	localparam logic [3:0] ST_VPREP = 4'd8;
	localparam logic [3:0] ST_VFIN  = 4'd9;
	localparam logic [3:0] ST_BAND  = 4'd10;
	localparam logic [3:0] ST_OUT   = 4'd11;
	localparam logic [3:0] ST_LIMIT = 4'd12;
	localparam logic [3:0] ST_SCALE = 4'd13;

	// configuration registers
	logic [21:0]        seg_len_q;
	logic [14:0]        max_ang_q;
	angle_t             init_ang_q;

	// block state
	angle_t             joint_q, abs_q;
	coord_t             end_x_q, end_y_q, mount_x_q, mount_y_q;

	logic [3:0]         state_q;
	logic [1:0]         op_q;
	coord_t             px_q, py_q;
	angle_t             pa_q;
	logic signed [24:0] rx_q, ry_q, qx_q, qy_q;
	logic               neg_q;
	logic signed [50:0] cz_q, dot_q, prod_q;
	logic signed [31:0] ad_q;
	logic               out_valid_q;

	// cordic connections
	logic               c_start, c_vec, c_done;
	logic signed [39:0] c_xi, c_yi, c_xr, c_yr;
	logic signed [31:0] c_zi, c_zr;

	ccd_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(c_start), .vectoring(c_vec),
		.x_init(c_xi), .y_init(c_yi), .z_init(c_zi), .done(c_done),
		.x_res(c_xr), .y_res(c_yr), .z_res(c_zr)
	);

	// shared multiplier, operand pair chosen by state
	logic signed [24:0] m_a, m_b;
	logic signed [49:0] m_p;
	always_comb begin
		case (state_q)
			ST_MUL0: begin m_a = rx_q; m_b = qy_q; end
			ST_MUL1: begin m_a = ry_q; m_b = qx_q; end
			ST_MUL2: begin m_a = rx_q; m_b = qx_q; end
			default: begin m_a = ry_q; m_b = qy_q; end
		endcase
	end
	assign m_p = m_a * m_b;

	// wrap of parent plus joint, one add and compare
	logic signed [17:0] sum_ang, wrapped;
	assign sum_ang = 18'(pa_q) + 18'(joint_q);
	always_comb begin
		if (sum_ang >= 18'sd23040)       wrapped = sum_ang - 18'sd46080;
		else if (sum_ang < -18'sd23040)  wrapped = sum_ang + 18'sd46080;
		else                             wrapped = sum_ang;
	end

	// rotation seed: length times 1/K, 30 x 22 bit product registered in ST_SCALE
	logic signed [39:0] seed_q;
	logic [51:0]        seed_prod;
	assign seed_prod = 52'(seg_len_q) * 52'(KINV_Q30);

	// vectoring prescale: shift so the larger magnitude is below 2^30
	// the vectoring y input is the magnitude of cross z when dot is not negative
	logic [50:0] mag_m;
	logic [50:0] cz_mag;
	logic [5:0]  sh;
	assign cz_mag = cz_q[50] ? 51'(-cz_q) : 51'(cz_q);
	always_comb begin
		logic [50:0] ax;
		ax    = dot_q[50] ? 51'(-dot_q) : 51'(dot_q);
		mag_m = (ax > cz_mag) ? ax : cz_mag;
		sh    = '0;
		for (int k = 0; k < 21; k++)
			if (mag_m[30 + k]) sh = 6'(k + 1);
	end
	logic signed [50:0] xs, ys;
	assign xs = dot_q >>> sh;
	assign ys = $signed(cz_mag) >>> sh;

	// rounded cordic outputs
	logic signed [31:0] rx_round, ry_round;
	logic signed [39:0] xf, yf;
	assign xf = neg_q ? -c_xr : c_xr;
	assign yf = neg_q ? -c_yr : c_yr;
	assign rx_round = 32'((xf + 40'sd128) >>> 8);
	assign ry_round = 32'((yf + 40'sd128) >>> 8);

	function automatic coord_t sat24(input logic signed [32:0] v);
		if (v > 33'sd8388607)       return 24'sd8388607;
		else if (v < -33'sd8388608) return -24'sd8388608;
		else                        return v[23:0];
	endfunction

	logic signed [31:0] zr_round;
	assign zr_round = (c_zr + 32'sd128) >>> 8;

	logic signed [17:0] jsum;
	logic signed [17:0] lim;
	assign lim  = 18'(max_ang_q);
	assign jsum = (cz_q > 0) ? 18'(joint_q) - 18'(ad_q) : 18'(joint_q) + 18'(ad_q);

	always_comb begin
		c_start = 1'b0;
		c_vec   = 1'b0;
		c_xi    = seed_q;
		c_yi    = '0;
		c_zi    = 32'(wrapped) <<< 8;
		if (state_q == ST_PREP) begin
			c_start = 1'b1;
			if (wrapped > 18'sd11520)       c_zi = 32'(wrapped - 18'sd23040) <<< 8;
			else if (wrapped < -18'sd11520) c_zi = 32'(wrapped + 18'sd23040) <<< 8;
		end else if (state_q == ST_VPREP) begin
			c_start = 1'b1;
			c_vec   = 1'b1;
			if (xs < 0) begin
				c_xi = 40'(ys);
				c_yi = 40'(-xs);
				c_zi = 32'(ANG_QUARTER) <<< 8;
			end else begin
				c_xi = 40'(xs);
				c_yi = 40'(ys);
				c_zi = '0;
			end
		end else if (state_q == ST_WAIT) begin
			c_vec = (op_q == OP_ROTATE);
		end
	end

	assign in_ch.ready = (state_q == ST_IDLE) && !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_len_q   <= '0;
			max_ang_q   <= 15'd23040;
			init_ang_q  <= '0;
			joint_q     <= '0;
			abs_q       <= '0;
			end_x_q     <= '0;
			end_y_q     <= '0;
			mount_x_q   <= '0;
			mount_y_q   <= '0;
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			op_q        <= '0;
			neg_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_LENGTH:  seg_len_q  <= cfg_data;
					REG_MAX:     max_ang_q  <= cfg_data[14:0];
					REG_INITIAL: init_ang_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						op_q <= in_ch.op;
						unique case (in_ch.op)
							OP_PLACE:  state_q <= ST_SCALE;
							OP_ROTATE: state_q <= ST_MUL0;
							OP_SET: begin
								joint_q <= in_ch.new_angle;
								state_q <= ST_OUT;
							end
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_SCALE: state_q <= ST_PREP;
				ST_PREP: begin
					abs_q   <= wrapped[15:0];
					neg_q   <= (wrapped > 18'sd11520) || (wrapped < -18'sd11520);
					state_q <= ST_WAIT;
				end
				ST_WAIT: if (c_done) state_q <= (op_q == OP_ROTATE) ? ST_VFIN : ST_PFIN;
				ST_PFIN: begin
					end_x_q   <= sat24(33'(px_q) + 33'(rx_round));
					end_y_q   <= sat24(33'(py_q) + 33'(ry_round));
					mount_x_q <= px_q;
					mount_y_q <= py_q;
					state_q   <= ST_OUT;
				end
				ST_MUL0: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_MUL3;
				ST_MUL3: state_q <= ST_VPREP;
				ST_VPREP: begin
					if (mag_m == 0 || (rx_q == 0 && ry_q == 0) || (qx_q == 0 && qy_q == 0)) begin
						ad_q    <= '0;
						state_q <= ST_BAND;
					end else begin
						state_q <= ST_WAIT;
					end
				end
				ST_VFIN: begin
					if (zr_round < 0)                 ad_q <= '0;
					else if (zr_round > 32'sd23040)   ad_q <= 32'sd23040;
					else                              ad_q <= zr_round;
					state_q <= ST_BAND;
				end
				ST_BAND: begin
					// band damping; divide by 3 through reciprocal multiply
					if (ad_q < 32'sd1280)      ad_q <= ad_q;
					else if (ad_q < 32'sd3840) ad_q <= ad_q >>> 1;
					else if (ad_q < 32'sd7680) ad_q <= 32'((ad_q * 32'sd43691) >>> 17);
					else                       ad_q <= ad_q >>> 2;
					state_q <= ST_LIMIT;
				end
				ST_LIMIT: begin
					if (jsum > lim)       joint_q <= lim[15:0];
					else if (jsum < -lim) joint_q <= 16'(-lim);
					else                  joint_q <= jsum[15:0];
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_ch.valid && in_ch.ready) begin
			px_q <= in_ch.parent_end_x;
			py_q <= in_ch.parent_end_y;
			pa_q <= in_ch.parent_angle;
			rx_q <= 25'(in_ch.target_x) - 25'(mount_x_q);
			ry_q <= 25'(in_ch.target_y) - 25'(mount_y_q);
			qx_q <= 25'(in_ch.tip_x) - 25'(mount_x_q);
			qy_q <= 25'(in_ch.tip_y) - 25'(mount_y_q);
		end
		if (state_q == ST_SCALE) seed_q <= 40'(seed_prod >> 22);
		unique case (state_q)
			ST_MUL0: prod_q <= 51'(m_p);
			ST_MUL1: cz_q   <= prod_q - 51'(m_p);
			ST_MUL2: prod_q <= 51'(m_p);
			ST_MUL3: dot_q  <= prod_q + 51'(m_p);
			default: ;
		endcase
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.end_x       = end_x_q;
	assign out_ch.end_y       = end_y_q;
	assign out_ch.abs_angle   = abs_q;
	assign out_ch.joint_angle = joint_q;
endmodule

@@ hdl/ccd_cordic.sv @@
// shared cordic unit: one micro-rotation per cycle, rotation or vectoring mode
// depends on ccd_pkg
module ccd_cordic #(
	parameter int STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               vectoring,
	input  logic signed [39:0] x_init,
	input  logic signed [39:0] y_init,
	input  logic signed [31:0] z_init,
	output logic               done,
	output logic signed [39:0] x_res,
	output logic signed [39:0] y_res,
	output logic signed [31:0] z_res
);
	import ccd_pkg::*;

	localparam int NSTEP = (STEPS > TABLE_LEN) ? TABLE_LEN : STEPS;

	logic signed [39:0] x_q, y_q;
	logic signed [31:0] z_q;
	logic [4:0]         i_q;
	logic               busy_q;
	logic               dir_up;
	logic signed [31:0] at;

	assign at     = signed'({11'd0, atan_lut(i_q)});
	assign dir_up = vectoring ? (y_q >= 0) : !(z_q >= 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q    <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				if (i_q == 5'(NSTEP - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				i_q <= i_q + 5'd1;
			end
		end
	end

	// dir_up: x += y>>i, y -= x>>i, z += atan
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x_init;
			y_q <= y_init;
			z_q <= z_init;
		end else if (busy_q) begin
			if (dir_up) begin
				x_q <= x_q + (y_q >>> i_q);
				y_q <= y_q - (x_q >>> i_q);
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - (y_q >>> i_q);
				y_q <= y_q + (x_q >>> i_q);
				z_q <= z_q - at;
			end
		end
	end

	assign x_res = x_q;
	assign y_res = y_q;
	assign z_res = z_q;
endmodule
